FILE: rtl/stable_four_level_priority_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-level priority queue
// Both macros assume a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef STABLE_FOUR_LEVEL_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_FOUR_LEVEL_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication.
`define SFPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sfpq_pkg.sv
// ----------------------------------------------------------------------------
// sfpq_pkg
// Shared types, codes and constants of the four-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpq_pkg;

    localparam int NUM_LEVELS      = 4;
    localparam int LEVEL_W         = 2;
    localparam int FIELD_ID_W      = 16;
    localparam int ROOM_W          = 2;
    localparam int TDATA_W         = 24;
    localparam int PAD_W           = TDATA_W - LEVEL_W - FIELD_ID_W;

    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // command codes (carried in tuser on the input)
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_CALL = 1'b1;

    // outcome codes (carried in tuser on the output)
    localparam logic OUTCOME_CALLED   = 1'b0;
    localparam logic OUTCOME_REJECTED = 1'b1;

    // urgency levels
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_SERIOUS  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_FAIR     = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_GOOD     = 2'd3;

    // rooms
    localparam logic [ROOM_W-1:0] ROOM_EMERGENCY    = 2'd0;
    localparam logic [ROOM_W-1:0] ROOM_EXAMINATION  = 2'd1;
    localparam logic [ROOM_W-1:0] ROOM_CONSULTATION = 2'd2;

    // per-item decision handed from the level control to the top level
    typedef struct packed {
        logic              result;      // item produces a result word
        logic              from_store;  // id comes from the entry store read
        logic              outcome;
        logic [ROOM_W-1:0] room;
    } sfpq_dec_t;

    function automatic logic [ROOM_W-1:0] room_of_level(input logic [LEVEL_W-1:0] lvl);
        logic [ROOM_W-1:0] r;
        case (lvl)
            LVL_CRITICAL: r = ROOM_EMERGENCY;
            LVL_SERIOUS:  r = ROOM_EXAMINATION;
            LVL_FAIR:     r = ROOM_CONSULTATION;
            LVL_GOOD:     r = ROOM_CONSULTATION;
            default:      r = ROOM_CONSULTATION;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sfpq_store.sv
// ----------------------------------------------------------------------------
// sfpq_store
// Entry store: one ring of LEVEL_DEPTH ids per level, one access per cycle,
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpq_store
    import sfpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
)
(
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic                                        rd_en,
    input  wire logic [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]   addr,
    input  wire logic [ID_WIDTH-1:0]                         wr_data,
    output logic      [ID_WIDTH-1:0]                         rd_data
);

    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

    logic [ID_WIDTH-1:0] mem [STORE_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/sfpq_ctrl.sv
// ----------------------------------------------------------------------------
// sfpq_ctrl
// Per-level head pointers and fill counts, priority encoder over the
// non-empty levels, and the add/call decision for the word in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpq_ctrl
    import sfpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH
)
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        item_valid,
    input  wire logic                                        item_cmd,
    input  wire logic [LEVEL_W-1:0]                          item_level,
    input  wire logic                                        fire,
    output sfpq_dec_t                                        dec,
    output logic                                             wr_en,
    output logic                                             rd_en,
    output logic      [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]   addr
);

    `include "stable_four_level_priority_queue_top_macros.svh"

    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int TOT_W  = CNT_W + LEVEL_W;

    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_reg   [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_next  [NUM_LEVELS];

    logic [NUM_LEVELS-1:0] not_empty;
    logic                  any_waiting;
    logic [LEVEL_W-1:0]    sel_lvl;
    logic                  add_full;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail_ptr;
    logic [PTR_W:0]        head_inc;
    logic [PTR_W-1:0]      head_adv;
    logic [ADDR_W-1:0]     add_addr;
    logic [ADDR_W-1:0]     call_addr;
    logic [TOT_W-1:0]      total_cnt;

    // priority encoder: lowest non-empty level wins
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            not_empty[l] = (cnt_reg[l] != '0);
        end
        any_waiting = |not_empty;
        sel_lvl     = LVL_GOOD;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (not_empty[l])
            begin
                sel_lvl = LEVEL_W'(l);
            end
        end
    end

    // tail = head + count, wrapped once (sum stays below twice the depth)
    always_comb
    begin
        tail_sum = SUM_W'(head_reg[item_level]) + SUM_W'(cnt_reg[item_level]);
        if (tail_sum >= SUM_W'(LEVEL_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(LEVEL_DEPTH);
        end
        tail_ptr = tail_sum[PTR_W-1:0];

        head_inc = {1'b0, head_reg[sel_lvl]} + (PTR_W+1)'(1);
        if (head_inc == (PTR_W+1)'(LEVEL_DEPTH))
        begin
            head_inc = '0;
        end
        head_adv = head_inc[PTR_W-1:0];

        add_addr  = ADDR_W'(item_level) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_ptr);
        call_addr = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_reg[sel_lvl]);
        add_full  = (cnt_reg[item_level] == CNT_W'(LEVEL_DEPTH));
    end

    always_comb
    begin
        dec            = '0;
        dec.outcome    = OUTCOME_CALLED;
        dec.room       = ROOM_EMERGENCY;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        addr           = add_addr;
        if (item_valid)
        begin
            case (item_cmd)
                CMD_ADD:
                begin
                    if (add_full)
                    begin
                        dec.result  = 1'b1;
                        dec.outcome = OUTCOME_REJECTED;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                CMD_CALL:
                begin
                    addr = call_addr;
                    if (any_waiting)
                    begin
                        dec.result     = 1'b1;
                        dec.from_store = 1'b1;
                        dec.room       = room_of_level(sel_lvl);
                        rd_en          = 1'b1;
                    end
                end
                default:
                begin
                    dec = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            cnt_next[l]  = cnt_reg[l];
        end
        if (fire && wr_en)
        begin
            cnt_next[item_level] = cnt_reg[item_level] + CNT_W'(1);
        end
        if (fire && rd_en)
        begin
            cnt_next[sel_lvl]  = cnt_reg[sel_lvl] - CNT_W'(1);
            head_next[sel_lvl] = head_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
        end
    end

    always_comb
    begin
        total_cnt = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            total_cnt = total_cnt + TOT_W'(cnt_reg[l]);
        end
    end

    `SFPQ_ASSERT_NOW(a_one_access, wr_en, !rd_en, "store written and read in one cycle")
    `SFPQ_ASSERT_NOW(a_reject_full, dec.result && !dec.from_store,
        cnt_reg[item_level] == CNT_W'(LEVEL_DEPTH), "add rejected on a level with room")
    `SFPQ_ASSERT_NEXT(a_call_pops, fire && rd_en,
        total_cnt == $past(total_cnt) - TOT_W'(1), "call did not remove exactly one entry")

endmodule

`default_nettype wire

FILE: rtl/stable_four_level_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_four_level_priority_queue_top
// Stable priority queue with four urgency levels and room assignment.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless a stalled output holds it. An add (tuser 0)
// puts the id at the back of its level; a call (tuser 1) pops the oldest id
// of the most urgent non-empty level and returns it with its room. An add
// into a full level comes back with tuser 1 and room 0; a successful add and
// a call on an empty queue return nothing. Each word goes through an input
// register and the decision logic; the result register and the store read
// register load at the same edge, and the result is shown from them; a
// stalled output holds only the words that need a result slot.
`default_nettype none

module stable_four_level_priority_queue_top
    import sfpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // patient_id[15:0], level[17:16], zero pad
    input  wire logic               s_tuser,   // cmd
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,   // called_id[15:0], room[17:16], zero pad
    output logic                    m_tuser    // outcome
);

    `include "stable_four_level_priority_queue_top_macros.svh"

    localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int EXT_W  = ID_WIDTH + FIELD_ID_W;

    // input stage
    logic                a_valid_reg;
    logic                a_cmd_reg;
    logic [ID_WIDTH-1:0] a_id_reg;
    logic [LEVEL_W-1:0]  a_level_reg;

    // result stage
    logic                b_valid_reg;
    logic                b_from_store_reg;
    logic                b_outcome_reg;
    logic [ROOM_W-1:0]   b_room_reg;
    logic [ID_WIDTH-1:0] b_rej_id_reg;

    sfpq_dec_t           dec;
    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   addr;
    logic [ID_WIDTH-1:0] rd_data;
    logic                b_free;
    logic                fire;
    logic                s_fire;
    logic [EXT_W-1:0]    in_ext;
    logic [EXT_W-1:0]    out_ext;
    logic [ID_WIDTH-1:0] out_id;

    assign in_ext = {{ID_WIDTH{1'b0}}, s_tdata[FIELD_ID_W-1:0]};

    assign b_free   = !b_valid_reg || m_tready;
    assign fire     = a_valid_reg && (!dec.result || b_free);
    assign s_tready = !a_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_cmd_reg   <= s_tuser;
            a_id_reg    <= in_ext[ID_WIDTH-1:0];
            a_level_reg <= s_tdata[FIELD_ID_W +: LEVEL_W];
        end
    end

    sfpq_ctrl #(
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (a_valid_reg),
        .item_cmd   (a_cmd_reg),
        .item_level (a_level_reg),
        .fire       (fire),
        .dec        (dec),
        .wr_en      (wr_en),
        .rd_en      (rd_en),
        .addr       (addr)
    );

    sfpq_store #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (fire && wr_en),
        .rd_en   (fire && rd_en),
        .addr    (addr),
        .wr_data (a_id_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (fire && dec.result)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && dec.result)
        begin
            b_from_store_reg <= dec.from_store;
            b_outcome_reg    <= dec.outcome;
            b_room_reg       <= dec.room;
            b_rej_id_reg     <= a_id_reg;
        end
    end

    // store read data is the register itself; only the source is selected here
    assign out_id  = b_from_store_reg ? rd_data : b_rej_id_reg;
    assign out_ext = {{FIELD_ID_W{1'b0}}, out_id};

    assign m_tvalid = b_valid_reg;
    assign m_tuser  = b_outcome_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, b_room_reg, out_ext[FIELD_ID_W-1:0]};

    `SFPQ_ASSERT_NEXT(a_result_held, b_valid_reg && !m_tready, b_valid_reg,
        "pending result dropped while stalled")
    `SFPQ_ASSERT_NEXT(a_item_held, a_valid_reg && !fire, a_valid_reg && $stable(a_cmd_reg),
        "input stage lost a word while waiting")
    `SFPQ_ASSERT_NOW(a_no_overwrite, fire && dec.result, b_free,
        "result slot overwritten before taken")

endmodule

`default_nettype wire
